[hdl/uart_event_frame_receiver_defines.svh]
// Assertion macros for the UART event frame receiver checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef UART_EVENT_FRAME_RECEIVER_DEFINES_SVH
`define UART_EVENT_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UEFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UEFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/uefr_pkg.sv]
// Shared types and constants for the UART event frame receiver.
// No dependencies; used by every module of the block.
package uefr_pkg;

  // Frame header and event codes
  localparam logic [7:0] SOF_BYTE       = 8'hAA;
  localparam logic [7:0] SENDER_BYTE    = 8'h57;
  localparam logic [7:0] EV_CONNECTION  = 8'hB3;
  localparam logic [7:0] EV_HID         = 8'hB4;
  localparam logic [7:0] EV_QUERY       = 8'hA2;
  localparam logic [7:0] EV_BATTERY     = 8'hB5;
  localparam logic [7:0] CMD_READ_REG   = 8'h25;
  localparam logic [7:0] REG_BATTERY    = 8'h05;
  localparam logic [7:0] NO_REGISTER    = 8'hFF;
  localparam logic [7:0] BATT_REPORT_OK = 8'h01;
  localparam logic [7:0] QUERY_STATUS_OK = 8'h00;

  // Connection sub-codes
  localparam logic [7:0] CONN_UP       = 8'h20;
  localparam logic [7:0] CONN_PAIR_A   = 8'h21;
  localparam logic [7:0] CONN_PAIR_B   = 8'h22;
  localparam logic [7:0] CONN_DOWN     = 8'h23;

  localparam int unsigned HEAD_DEPTH      = 6;
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  // Frame queue between parser and state update
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Battery scale 2.29: floor(raw * 229 / 100) == (raw * BATT_MULT) >> BATT_SHIFT
  // for every 16-bit raw value.
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned BATT_SHIFT  = 24;
  localparam int unsigned BATT_MULT_W = 26;
  localparam logic [BATT_MULT_W-1:0] BATT_MULT = 26'd38419825;
  localparam int unsigned BATT_PROD_W = RAW_W + BATT_MULT_W;

  typedef enum logic [1:0] {
    LINK_DOWN    = 2'd0,
    LINK_PAIRING = 2'd1,
    LINK_UP      = 2'd2
  } link_e;

  // One completed frame, classified by the parser
  typedef struct packed {
    logic               ok;
    logic [7:0]         ev_code;
    logic [7:0]         seq;
    logic               ack;       // connection event: also loads host
    logic [7:0]         host;
    logic               link_we;
    link_e              link;
    logic               caps_we;
    logic               caps;
    logic               batt_we;
    logic [RAW_W-1:0]   batt_raw;
  } frame_rec_t;

endpackage

[hdl/uefr_front.sv]
// Byte parser: header, length check, payload capture, checksum and event
// classification. Depends on uefr_pkg.
module uefr_front #(
  parameter int unsigned MaxPayload = uefr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [7:0]             byte_value_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output uefr_pkg::frame_rec_t   rec_o
);
  import uefr_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SENDER = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_NLEN   = 3'd3;
  localparam logic [2:0] PH_SEQ    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  head_q [HEAD_DEPTH];
  logic [7:0]  head_d [HEAD_DEPTH];
  logic [7:0]  dbyte [HEAD_DEPTH];

  logic        accept, byte_acc, data_ok, last_pos;
  logic        len_ok, sum_ok, good, clr_pend;
  frame_rec_t  rec;

  // Only a completing frame needs queue room; stall whenever the queue is full
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign byte_acc   = accept && !kind_i;
  assign data_ok    = (phase_q == PH_DATA) && (count_q < len_q);
  assign last_pos   = data_ok && (8'(count_q + 8'd1) == len_q);

  assign push_valid_o = byte_acc && last_pos;
  assign rec_o        = rec;

  // Payload bytes at or past the checksum read as zero
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      dbyte[i] = (len_q >= 8'(i + 3)) ? head_q[i] : 8'h00;
    end
  end

  assign len_ok = (len_q >= 8'd3) && (len_q <= 8'(MaxPayload));
  // Sum of data bytes equals the little-endian checksum {newest, previous}
  assign sum_ok = (16'(sum_q - {8'h00, prev_q})) == {byte_value_i, prev_q};
  assign good   = len_ok && sum_ok;

  always_comb begin
    rec         = '0;
    clr_pend    = 1'b0;
    rec.ok      = good;
    rec.ev_code = dbyte[0];
    rec.seq     = seq_q;
    if (good) begin
      unique case (dbyte[0])
        EV_CONNECTION: begin
          rec.ack  = 1'b1;
          rec.host = dbyte[3];
          unique case (dbyte[1])
            CONN_UP: begin
              rec.link_we = 1'b1;
              rec.link    = LINK_UP;
            end
            CONN_PAIR_A, CONN_PAIR_B: begin
              rec.link_we = 1'b1;
              rec.link    = LINK_PAIRING;
            end
            CONN_DOWN: begin
              rec.link_we = 1'b1;
              rec.link    = LINK_DOWN;
            end
            default: ;
          endcase
        end
        EV_HID: begin
          rec.caps_we = 1'b1;
          rec.caps    = |dbyte[1];
        end
        EV_QUERY: begin
          if (dbyte[3] == QUERY_STATUS_OK && dbyte[2] == CMD_READ_REG) begin
            clr_pend     = 1'b1;
            rec.batt_we  = (pend_q == REG_BATTERY);
            rec.batt_raw = {dbyte[5], dbyte[4]};
          end
        end
        EV_BATTERY: begin
          if (dbyte[1] == BATT_REPORT_OK) begin
            rec.batt_we  = 1'b1;
            rec.batt_raw = {dbyte[3], dbyte[2]};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seq_d   = seq_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    count_d = count_q;
    pend_d  = pend_q;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_d[i] = head_q[i];
    end
    if (accept) begin
      if (kind_i) begin
        pend_d = byte_value_i;
      end else begin
        priority if (phase_q == PH_IDLE && byte_value_i == SOF_BYTE) begin
          phase_d = PH_SENDER;
        end else if (phase_q == PH_SENDER && byte_value_i == SENDER_BYTE) begin
          phase_d = PH_LEN;
        end else if (phase_q == PH_LEN) begin
          len_d   = byte_value_i;
          phase_d = PH_NLEN;
        end else if (phase_q == PH_NLEN) begin
          phase_d = (byte_value_i == ~len_q) ? PH_SEQ : PH_IDLE;
        end else if (phase_q == PH_SEQ) begin
          seq_d   = byte_value_i;
          sum_d   = '0;
          prev_d  = '0;
          count_d = '0;
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_d[i] = '0;
          end
          phase_d = PH_DATA;
        end else if (data_ok) begin
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            if (count_q == 8'(i)) head_d[i] = byte_value_i;
          end
          sum_d   = 16'(sum_q + {8'h00, byte_value_i});
          prev_d  = byte_value_i;
          count_d = 8'(count_q + 8'd1);
          if (last_pos) begin
            phase_d = PH_IDLE;
            len_d   = '0;
            seq_d   = '0;
            if (clr_pend) pend_d = NO_REGISTER;
          end
        end else begin
          // Drop the byte and hunt for the next start byte
          phase_d = PH_IDLE;
          len_d   = '0;
          seq_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      seq_q   <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
      count_q <= '0;
      pend_q  <= NO_REGISTER;
      head_q  <= '{default: '0};
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      head_q  <= head_d;
    end
  end

endmodule

[hdl/uefr_queue.sv]
// Short queue of classified frames between parser and state update.
// Depends on uefr_pkg.
module uefr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  uefr_pkg::frame_rec_t rec_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output uefr_pkg::frame_rec_t rec_o
);
  import uefr_pkg::*;

  frame_rec_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign rec_o        = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop) begin
        cnt_q <= QCNT_W'(cnt_q + 1'b1);
      end else if (pop && !push) begin
        cnt_q <= QCNT_W'(cnt_q - 1'b1);
      end
    end
  end

endmodule

[hdl/uefr_back.sv]
// Link state update, battery scaling and registered result stage.
// Depends on uefr_pkg.
module uefr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  uefr_pkg::frame_rec_t rec_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 frame_ok_o,
  output logic [7:0]           event_code_o,
  output logic [7:0]           sequence_res_o,
  output logic                 send_ack_o,
  output logic [1:0]           link_status_o,
  output logic [7:0]           host_index_o,
  output logic                 caps_lock_o,
  output logic [15:0]          battery_value_o
);
  import uefr_pkg::*;

  logic                   valid_q;
  logic                   ok_q, ack_q;
  logic [7:0]             ev_q, seq_q;
  link_e                  link_q;
  logic [7:0]             host_q;
  logic                   caps_q;
  logic [15:0]            volt_q, volt_d;
  logic [BATT_PROD_W-1:0] prod;
  logic                   take;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  assign prod = BATT_PROD_W'(rec_i.batt_raw) * BATT_PROD_W'(BATT_MULT);
  // Saturate the scaled value to 16 bits
  assign volt_d = (|prod[BATT_PROD_W-1:BATT_SHIFT+16]) ? 16'hFFFF
                                                       : prod[BATT_SHIFT+15:BATT_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      link_q  <= LINK_DOWN;
      host_q  <= '0;
      caps_q  <= 1'b0;
      volt_q  <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        if (rec_i.link_we) link_q <= rec_i.link;
        if (rec_i.ack)     host_q <= rec_i.host;
        if (rec_i.caps_we) caps_q <= rec_i.caps;
        if (rec_i.batt_we) volt_q <= volt_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ok_q  <= rec_i.ok;
      ack_q <= rec_i.ack;
      ev_q  <= rec_i.ev_code;
      seq_q <= rec_i.seq;
    end
  end

  // State only moves when a new result loads, so it doubles as the result
  assign out_valid_o     = valid_q;
  assign frame_ok_o      = ok_q;
  assign send_ack_o      = ack_q;
  assign event_code_o    = ev_q;
  assign sequence_res_o  = seq_q;
  assign link_status_o   = link_q;
  assign host_index_o    = host_q;
  assign caps_lock_o     = caps_q;
  assign battery_value_o = volt_q;

endmodule

[hdl/uart_event_frame_receiver.sv]
// Top level of the UART event frame receiver: parser, frame queue and
// state update stage. Depends on uefr_pkg, uefr_front, uefr_queue, uefr_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i, in_ready_o | kind_i, byte_value_i
//  out     | out_valid_o, out_ready_i | frame_ok_o, event_code_o, sequence_res_o,
//          |                        | send_ack_o, link_status_o, host_index_o,
//          |                        | caps_lock_o, battery_value_o
//
// One item is taken per cycle while in_ready_o is high; the parser handles each byte
// in the cycle it arrives. After its last byte, the result of a frame passes through
// the frame queue and then the output register before it is shown.
// in_ready_o drops only while the two-entry frame queue is full, i.e. when two
// completed frames wait behind a result that the output side holds off.
// Reset clears all control and link state at once; no clearing pass.
module uart_event_frame_receiver #(
  parameter int unsigned MaxPayload = uefr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic [7:0]  event_code_o,
  output logic [7:0]  sequence_res_o,
  output logic        send_ack_o,
  output logic [1:0]  link_status_o,
  output logic [7:0]  host_index_o,
  output logic        caps_lock_o,
  output logic [15:0] battery_value_o
);
  import uefr_pkg::*;

  // Parser to queue
  logic       push_valid, push_ready;
  frame_rec_t push_rec;
  // Queue to state update
  logic       pop_valid, pop_ready;
  frame_rec_t pop_rec;

  // Parse bytes, track the pending register read and classify each frame
  uefr_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .byte_value_i(byte_value_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .rec_o       (push_rec)
  );

  // Hold classified frames so the parser keeps going while results wait
  uefr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .rec_i       (push_rec),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .rec_o       (pop_rec)
  );

  // Apply updates in frame order and present the result
  uefr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .rec_i          (pop_rec),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_ok_o     (frame_ok_o),
    .event_code_o   (event_code_o),
    .sequence_res_o (sequence_res_o),
    .send_ack_o     (send_ack_o),
    .link_status_o  (link_status_o),
    .host_index_o   (host_index_o),
    .caps_lock_o    (caps_lock_o),
    .battery_value_o(battery_value_o)
  );

endmodule

[hdl/uefr_checker.sv]
// Port-level checker for the UART event frame receiver, bound to the top.
// Depends on uefr_pkg and uart_event_frame_receiver_defines.svh.
`include "uart_event_frame_receiver_defines.svh"

module uefr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        kind_i,
  input logic [7:0]  byte_value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_ok_o,
  input logic [7:0]  event_code_o,
  input logic [7:0]  sequence_res_o,
  input logic        send_ack_o,
  input logic [1:0]  link_status_o,
  input logic [7:0]  host_index_o,
  input logic        caps_lock_o,
  input logic [15:0] battery_value_o
);
  import uefr_pkg::*;

  logic [44:0] res_bus;
  logic [8:0]  in_bus;
  logic        out_stall, in_stall, ack_seen;

  assign res_bus   = {frame_ok_o, event_code_o, sequence_res_o, send_ack_o, link_status_o,
                      host_index_o, caps_lock_o, battery_value_o};
  assign in_bus    = {kind_i, byte_value_i};
  assign out_stall = out_valid_o && !out_ready_i;
  assign in_stall  = in_valid_i && !in_ready_o;
  assign ack_seen  = out_valid_o && send_ack_o;

  // Hold a stalled result
  `UEFR_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(res_bus), "result moved")
  // Hold a stalled item
  `UEFR_ASSERT_NXT(a_in_hold, in_stall, in_valid_i && $stable(in_bus), "item moved")
  // Acknowledge only for a good connection frame
  `UEFR_ASSERT_IMP(a_ack_ok, ack_seen, frame_ok_o, "ack on bad frame")
  `UEFR_ASSERT_IMP(a_ack_conn, ack_seen, event_code_o == EV_CONNECTION, "ack on other event")
  // Link status never takes the unused code
  `UEFR_ASSERT_IMP(a_link_range, out_valid_o, link_status_o <= LINK_UP, "link out of range")

endmodule

bind uart_event_frame_receiver uefr_checker u_checker (.*);

[test/tb.sv]
// Self-checking testbench for uart_event_frame_receiver: streams framed UART bytes and
// register-read notices, predicts every completed frame and checks each result field.
// Depends on uefr_pkg (hdl/uefr_pkg.sv) and the block's RTL; reads no files.
`timescale 1ns / 100ps

module tb;
  import uefr_pkg::*;

  localparam int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
  localparam int unsigned ITEM_TARGET  = 1850;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned STALL_AT     = 600;     // accepted items before the long hold-off
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned QUIET_FROM   = 1000;    // accepted-item window with no idling
  localparam int unsigned QUIET_TO     = 1400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned BATT_NUM     = 229;
  localparam int unsigned BATT_DEN     = 100;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Parser position inside a frame
  typedef enum logic [2:0] {
    P_SOF, P_SENDER, P_LEN, P_NLEN, P_SEQ, P_DATA
  } parse_e;

  // One item to offer; a drain entry is not sent but holds the sender back
  // until every outstanding frame result has been checked.
  typedef struct packed {
    logic       drain;
    logic       kind;
    logic [7:0] value;
  } stim_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  ev;
    logic [7:0]  seq;
    logic        ack;
    logic [1:0]  link;
    logic [7:0]  host;
    logic        caps;
    logic [15:0] batt;
  } frame_res_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        kind_i       = 1'b0;
  logic [7:0]  byte_value_i = 8'h00;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        frame_ok_o;
  logic [7:0]  event_code_o;
  logic [7:0]  sequence_res_o;
  logic        send_ack_o;
  logic [1:0]  link_status_o;
  logic [7:0]  host_index_o;
  logic        caps_lock_o;
  logic [15:0] battery_value_o;

  stim_t       pending_bytes[$];
  frame_res_t  expected_frames[$];
  logic [7:0]  body_q[$];

  int unsigned n_items       = 0;   // items queued that the parser acts on
  int unsigned n_accepted    = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycles        = 0;
  int unsigned rx_stall_left = 0;
  logic        rx_stall_done = 1'b0;
  logic        in_fire       = 1'b0;
  logic        quiet_window;

  assign quiet_window = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

  // Shadow of the parser: frame position, payload sums and the first payload bytes
  parse_e      rx_phase;
  logic [7:0]  rx_len;
  logic [7:0]  rx_seq;
  logic [7:0]  rx_cnt;
  logic [15:0] rx_sum;
  logic [15:0] rx_tail;
  logic [7:0]  rx_head [HEAD_DEPTH];
  // Shadow of the link state that valid frames update
  link_e       lk_status;
  logic [7:0]  lk_host;
  logic        lk_caps;
  logic [15:0] lk_batt;
  logic [7:0]  lk_pend_reg;

  uart_event_frame_receiver #(
    .MaxPayload(MAX_PAYLOAD)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_ok_o     (frame_ok_o),
    .event_code_o   (event_code_o),
    .sequence_res_o (sequence_res_o),
    .send_ack_o     (send_ack_o),
    .link_status_o  (link_status_o),
    .host_index_o   (host_index_o),
    .caps_lock_o    (caps_lock_o),
    .battery_value_o(battery_value_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Payload byte i as the event decoder sees it: anything at or past the
  // checksum, or past the stored head, reads as zero.
  function automatic logic [7:0] head_at(input int unsigned i);
    int unsigned lim;
    lim = (rx_len >= 8'd3) ? int'(rx_len) - 2 : 0;
    if (i >= lim || i >= HEAD_DEPTH) return 8'h00;
    return rx_head[i];
  endfunction

  // Battery scale 2.29 in integers, saturated to 16 bits
  function automatic logic [15:0] scale_battery(input logic [15:0] raw);
    int unsigned v;
    v = 32'(raw) * BATT_NUM / BATT_DEN;
    return (v > 32'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  // Advance the shadow parser by one accepted item; return 1 with the
  // expected result when the item completes a frame.
  function automatic bit parse_byte(input logic kind, input logic [7:0] b,
                                    output frame_res_t r);
    bit          ok;
    bit          ack;
    logic [7:0]  ev;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] chk;
    ok  = 1'b0;
    ack = 1'b0;
    r   = '0;
    // A read notice only records the register; parsing carries on untouched
    if (kind == KIND_READ) begin
      lk_pend_reg = b;
      return 1'b0;
    end
    if (rx_phase == P_SOF && b == SOF_BYTE) begin
      rx_phase = P_SENDER;
    end else if (rx_phase == P_SENDER && b == SENDER_BYTE) begin
      rx_phase = P_LEN;
    end else if (rx_phase == P_LEN) begin
      rx_len   = b;
      rx_phase = P_NLEN;
    end else if (rx_phase == P_NLEN) begin
      rx_phase = (b == ~rx_len) ? P_SEQ : P_SOF;
    end else if (rx_phase == P_SEQ) begin
      rx_seq  = b;
      rx_sum  = '0;
      rx_tail = '0;
      rx_cnt  = '0;
      for (int i = 0; i < HEAD_DEPTH; i++) rx_head[i] = 8'h00;
      rx_phase = P_DATA;
    end else if (rx_phase == P_DATA && rx_cnt < rx_len) begin
      if (rx_cnt < HEAD_DEPTH) rx_head[rx_cnt[2:0]] = b;
      rx_sum  = rx_sum + {8'h00, b};
      rx_tail = {rx_tail[7:0], b};
      rx_cnt  = rx_cnt + 8'd1;
      if (rx_cnt == rx_len) begin
        // Checksum: little-endian sum of everything before the last two bytes
        if (rx_len >= 8'd3 && rx_len <= MAX_PAYLOAD) begin
          lo  = rx_tail[15:8];
          hi  = rx_tail[7:0];
          chk = rx_sum - {8'h00, lo} - {8'h00, hi};
          ok  = (chk == {hi, lo});
        end
        if (ok) begin
          ev = head_at(0);
          if (ev == EV_CONNECTION) begin
            ack = 1'b1;
            case (head_at(1))
              CONN_UP:                  lk_status = LINK_UP;
              CONN_PAIR_A, CONN_PAIR_B: lk_status = LINK_PAIRING;
              CONN_DOWN:                lk_status = LINK_DOWN;
              default:                  ;
            endcase
            lk_host = head_at(3);
          end else if (ev == EV_HID) begin
            lk_caps = (head_at(1) != 8'h00);
          end else if (ev == EV_QUERY) begin
            // Only a successful register-read answer counts, and it clears
            // whatever read was pending
            if (head_at(3) == QUERY_STATUS_OK && head_at(2) == CMD_READ_REG) begin
              if (lk_pend_reg == REG_BATTERY)
                lk_batt = scale_battery({head_at(5), head_at(4)});
              lk_pend_reg = NO_REGISTER;
            end
          end else if (ev == EV_BATTERY) begin
            if (head_at(1) == BATT_REPORT_OK)
              lk_batt = scale_battery({head_at(3), head_at(2)});
          end
        end
        r.ok   = ok;
        r.ev   = head_at(0);
        r.seq  = rx_seq;
        r.ack  = ack;
        r.link = lk_status;
        r.host = lk_host;
        r.caps = lk_caps;
        r.batt = lk_batt;
        rx_phase = P_SOF;
        rx_len   = '0;
        rx_seq   = '0;
        return 1'b1;
      end
    end else begin
      // Anything out of step: drop it and hunt for a new start byte
      rx_phase = P_SOF;
      rx_len   = '0;
      rx_seq   = '0;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b);
    pending_bytes.push_back('{drain: 1'b0, kind: KIND_BYTE, value: b});
  endtask

  task automatic put_read(input logic [7:0] r);
    pending_bytes.push_back('{drain: 1'b0, kind: KIND_READ, value: r});
    n_items++;
  endtask

  task automatic put_pause();
    pending_bytes.push_back('{drain: 1'b1, kind: KIND_BYTE, value: 8'h00});
  endtask

  // Mostly the wanted code, now and then anything
  function automatic logic [7:0] pick_code(input logic [7:0] want);
    return ($urandom_range(0, 99) < 85) ? want : 8'($urandom);
  endfunction

  // Queue a complete frame of length len. body_q gives the data bytes (random
  // where it runs short); for lengths of three or more the last two bytes
  // carry the checksum, optionally corrupted. Read notices may be slipped in.
  task automatic send_frame(input int unsigned len, input logic [7:0] seq,
                            input bit bad_sum, input int unsigned notice_pct);
    logic [15:0] sum;
    logic [7:0]  d;
    sum = '0;
    put_byte(SOF_BYTE);
    put_byte(SENDER_BYTE);
    put_byte(8'(len));
    put_byte(~8'(len));
    put_byte(seq);
    for (int unsigned i = 0; i < len; i++) begin
      if (len >= 3 && i == len - 2) begin
        d = bad_sum ? (sum[7:0] ^ 8'($urandom_range(1, 255))) : sum[7:0];
      end else if (len >= 3 && i == len - 1) begin
        d = sum[15:8];
      end else begin
        d   = (i < body_q.size()) ? body_q[i] : 8'($urandom);
        sum = sum + {8'h00, d};
      end
      if ($urandom_range(0, 99) < notice_pct) put_read(pick_code(REG_BATTERY));
      put_byte(d);
    end
    n_items += len + 5;
  endtask

  // Fill body_q with one event of random type and content
  task automatic fill_event_body();
    logic [15:0] raw;
    logic [7:0]  sub;
    int unsigned keep;
    case ($urandom_range(0, 3))
      0:       raw = 16'h0000;
      1:       raw = 16'hFFFF;
      default: raw = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       sub = CONN_UP;
      1:       sub = CONN_PAIR_A;
      2:       sub = CONN_PAIR_B;
      3:       sub = CONN_DOWN;
      default: sub = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: body_q = '{EV_CONNECTION, sub, 8'($urandom), 8'($urandom)};
      1: body_q = '{EV_HID, ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom)};
      2: body_q = '{EV_QUERY, 8'($urandom), pick_code(CMD_READ_REG),
                    pick_code(QUERY_STATUS_OK), raw[7:0], raw[15:8]};
      3: body_q = '{EV_BATTERY, pick_code(BATT_REPORT_OK), raw[7:0], raw[15:8]};
      default: body_q = '{8'($urandom), 8'($urandom)};
    endcase
    // Cut some bodies short so that later fields fall past the data
    if ($urandom_range(0, 3) == 0) begin
      keep = $urandom_range(1, body_q.size());
      while (body_q.size() > keep) void'(body_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reset and stimulus
  // ---------------------------------------------------------------------------

  initial begin : reset_seq
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned sel;
    bit          pause_placed;
    pause_placed = 1'b0;

    // Shadow state after reset
    rx_phase    = P_SOF;
    rx_len      = '0;
    rx_seq      = '0;
    rx_cnt      = '0;
    rx_sum      = '0;
    rx_tail     = '0;
    for (int i = 0; i < HEAD_DEPTH; i++) rx_head[i] = 8'h00;
    lk_status   = LINK_DOWN;
    lk_host     = '0;
    lk_caps     = 1'b0;
    lk_batt     = '0;
    lk_pend_reg = NO_REGISTER;

    // --- Directed part ---
    // unknown code straight after reset, then every event type in turn
    body_q = '{8'h00};
    send_frame(3, 8'h00, 1'b0, 0);
    body_q = '{EV_HID, 8'h01};
    send_frame(4, 8'hFF, 1'b0, 0);
    body_q = '{EV_CONNECTION, CONN_UP, 8'h00, 8'hFF};
    send_frame(6, 8'h01, 1'b0, 0);
    body_q = '{EV_CONNECTION, CONN_PAIR_A, 8'h00, 8'h01};
    send_frame(6, 8'h02, 1'b0, 0);
    body_q = '{EV_CONNECTION, CONN_PAIR_B, 8'hFF, 8'h02};
    send_frame(6, 8'h03, 1'b0, 0);
    body_q = '{EV_CONNECTION, CONN_DOWN, 8'h00, 8'h03};
    send_frame(6, 8'h04, 1'b0, 0);
    body_q = '{EV_CONNECTION, 8'h7F, 8'h00, 8'h04};
    send_frame(6, 8'h05, 1'b0, 0);
    // connection event with no room for the host byte: host reads as zero
    body_q = '{EV_CONNECTION};
    send_frame(3, 8'h06, 1'b0, 0);
    body_q = '{EV_HID, 8'h00};
    send_frame(4, 8'h07, 1'b0, 0);
    // battery register read with the largest raw value: scale saturates
    put_read(REG_BATTERY);
    body_q = '{EV_QUERY, 8'h00, CMD_READ_REG, QUERY_STATUS_OK, 8'hFF, 8'hFF};
    send_frame(8, 8'h08, 1'b0, 0);
    // failed status: ignored, read stays pending
    put_read(REG_BATTERY);
    body_q = '{EV_QUERY, 8'h00, CMD_READ_REG, 8'h80, 8'h34, 8'h12};
    send_frame(8, 8'h09, 1'b0, 0);
    // answer to some other register: clears the pending read, battery kept
    put_read(8'h07);
    body_q = '{EV_QUERY, 8'h00, CMD_READ_REG, QUERY_STATUS_OK, 8'h34, 8'h12};
    send_frame(8, 8'h0A, 1'b0, 0);
    // battery reports: zero, mid value, then a bad report code
    body_q = '{EV_BATTERY, BATT_REPORT_OK, 8'h00, 8'h00};
    send_frame(6, 8'h0B, 1'b0, 0);
    body_q = '{EV_BATTERY, BATT_REPORT_OK, 8'h34, 8'h12};
    send_frame(6, 8'h0C, 1'b0, 0);
    body_q = '{EV_BATTERY, 8'h02, 8'hFF, 8'hFF};
    send_frame(6, 8'h0D, 1'b0, 0);
    // read notices in the middle of a query answer
    put_read(REG_BATTERY);
    body_q = '{EV_QUERY, 8'h00, CMD_READ_REG, QUERY_STATUS_OK, 8'h00, 8'h80};
    send_frame(8, 8'h0E, 1'b0, 40);
    // checksum mismatch on an otherwise good frame
    body_q = '{EV_HID, 8'h01};
    send_frame(4, 8'h0F, 1'b1, 0);
    // bad lengths: one, two, just over the limit and the largest
    body_q.delete();
    send_frame(1, 8'h10, 1'b0, 0);
    send_frame(2, 8'h11, 1'b0, 0);
    send_frame(MAX_PAYLOAD + 1, 8'h12, 1'b0, 0);
    for (int i = 0; i < 253; i++) body_q.push_back(8'hFF);
    send_frame(255, 8'h13, 1'b0, 0);
    // zero length: the byte after the sequence number is dropped
    put_byte(SOF_BYTE); put_byte(SENDER_BYTE); put_byte(8'h00); put_byte(8'hFF);
    put_byte(8'h14); put_byte(8'hB4);
    // inverted length wrong
    put_byte(SOF_BYTE); put_byte(SENDER_BYTE); put_byte(8'h04); put_byte(8'h04);
    // broken header: repeated start byte, stray sender byte
    put_byte(SOF_BYTE); put_byte(SOF_BYTE); put_byte(SENDER_BYTE); put_byte(8'h00);
    n_items += 14;
    body_q = '{EV_HID, 8'h80};
    send_frame(4, 8'h15, 1'b0, 0);
    put_pause();

    // --- Random part: mostly well-formed frames, some broken ones and noise ---
    while (n_items < ITEM_TARGET) begin
      if (!pause_placed && n_items >= 1200) begin
        put_pause();
        pause_placed = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        fill_event_body();
        if (body_q[0] == EV_QUERY && $urandom_range(0, 9) < 7)
          put_read(pick_code(REG_BATTERY));
        len = body_q.size() + 2 + $urandom_range(0, 2);
        send_frame(len, 8'($urandom), sel >= 72, 3);
      end else if (sel < 86) begin
        body_q.delete();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: len = $urandom_range(1, 2);
          5, 6, 7, 8:    len = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 8);
          default:       len = $urandom_range(MAX_PAYLOAD + 9, 255);
        endcase
        send_frame(len, 8'($urandom), 1'b0, 3);
      end else if (sel < 90) begin
        len = $urandom_range(0, 255);
        put_byte(SOF_BYTE); put_byte(SENDER_BYTE); put_byte(8'(len));
        put_byte(~8'(len) ^ 8'($urandom_range(1, 255)));
        n_items += 4;
      end else if (sel < 94) begin
        put_byte(SOF_BYTE); put_byte(8'($urandom));
        n_items += 2;
      end else if (sel < 97) begin
        put_byte(SOF_BYTE); put_byte(SENDER_BYTE); put_byte(8'h00); put_byte(8'hFF);
        put_byte(8'($urandom)); put_byte(8'($urandom));
        n_items += 6;
      end else begin
        put_read(8'($urandom));
      end
      // stray line noise between frames; the parser drops it
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    end

    // Wait for every item to go in, every result to come out, then settle
    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver: advance on acceptance, idle at random outside steady stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_in
    stim_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pending_bytes.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_bytes[0].drain) begin
        // hold back until the output side has caught up completely
        if (expected_frames.size() == 0) void'(pending_bytes.pop_front());
        in_valid_i <= 1'b0;
      end else if (!quiet_window && rx_stall_left == 0 &&
                   $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
      end else begin
        cur = pending_bytes.pop_front();
        in_valid_i   <= 1'b1;
        kind_i       <= cur.kind;
        byte_value_i <= cur.value;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output ready: random stalls, one long hold-off while the sender keeps
  // offering so the frame queue fills and the input stalls
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_stall_left != 0) begin
      out_ready_i   <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (!rx_stall_done && n_accepted >= STALL_AT) begin
      out_ready_i   <= 1'b0;
      rx_stall_left <= STALL_CYCLES;
      rx_stall_done <= 1'b1;
    end else if (quiet_window) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results against the oldest expectation, then predict from
  // any item accepted at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    frame_res_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $error("result with no frame outstanding: seq 0x%0h", sequence_res_o);
          err_cnt++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_ok",      16'(want.ok),   16'(frame_ok_o));
          check_field("event_code",    16'(want.ev),   16'(event_code_o));
          check_field("sequence_res",  16'(want.seq),  16'(sequence_res_o));
          check_field("send_ack",      16'(want.ack),  16'(send_ack_o));
          check_field("link_status",   16'(want.link), 16'(link_status_o));
          check_field("host_index",    16'(want.host), 16'(host_index_o));
          check_field("caps_lock",     16'(want.caps), 16'(caps_lock_o));
          check_field("battery_value", want.batt,      battery_value_o);
        end
      end
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        n_accepted++;
        if (parse_byte(kind_i, byte_value_i, want)) expected_frames.push_back(want);
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule

[files.f]
+incdir+hdl
hdl/uefr_pkg.sv
hdl/uefr_front.sv
hdl/uefr_queue.sv
hdl/uefr_back.sv
hdl/uart_event_frame_receiver.sv
hdl/uefr_checker.sv
test/tb.sv
